/* design/gaussian_output_update_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian output update block
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_OUTPUT_UPDATE_ASSERT_SVH
`define GAUSSIAN_OUTPUT_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define GOU_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("gou implication failed");

// Next-cycle implication, checked also around reset.
`define GOU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error("gou next-cycle check failed");

`endif

/* design/gou_pkg.sv */
// ----------------------------------------------------------------------------
// gou_pkg
// Constants, stage types and helper functions of the Gaussian output update.
// ----------------------------------------------------------------------------
package gou_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int VAR_W     = 31;
    localparam int NUM_W     = 62;
    localparam int DIFF_W    = 33;
    localparam int QUO_W     = 32;
    localparam int MPROD_W   = QUO_W + DIFF_W;
    localparam int PPROD_W   = QUO_W + VAR_W;
    localparam int VPROD_W   = QUO_W + NUM_W;

    localparam logic [QUO_W-1:0] POS_CAP = 32'h7fff_ffff;
    localparam logic [QUO_W-1:0] NEG_CAP = 32'h8000_0000;

    // Payload of one divider stage.
    typedef struct packed {
        logic [QUO_W-1:0]  rem;
        logic [QUO_W-1:0]  quo;
        logic [NUM_W-1:0]  num;
        logic [QUO_W-1:0]  den;
        logic              ovf;
        logic              jneg;
        logic              dneg;
        logic [DIFF_W-1:0] dmag;
        logic              last;
    } t_div;

    // One restoring division step that brings down numerator bit b.
    function automatic t_div div_step(t_div s, int b);
        t_div              r;
        logic [QUO_W:0]    t;
        r = s;
        t = {s.rem, s.num[b]};
        if (t >= {1'b0, s.den}) begin
            t        = t - {1'b0, s.den};
            r.quo[b] = 1'b1;
        end
        r.rem = t[QUO_W-1:0];
        return r;
    endfunction

    // Signed 32-bit result from a magnitude and a sign, saturated.
    function automatic logic [DATA_W-1:0] sat_mag(logic neg, logic [VPROD_W-1:0] mag);
        logic [VPROD_W-1:0] cap;
        logic [DATA_W-1:0]  m;
        cap = neg ? VPROD_W'(NEG_CAP) : VPROD_W'(POS_CAP);
        m   = (mag > cap) ? cap[DATA_W-1:0] : mag[DATA_W-1:0];
        return neg ? (DATA_W'(0) - m) : m;
    endfunction

endpackage

/* design/gou_if.sv */
// ----------------------------------------------------------------------------
// gou_in_if / gou_out_if
// Valid-ready channels carrying one unit's operands and one unit's result.
// ----------------------------------------------------------------------------
interface gou_in_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  jacobian;
    logic        [30:0]  state_var;
    logic signed [31:0]  act_mean;
    logic        [30:0]  act_var;
    logic signed [31:0]  observation;
    logic        [30:0]  noise_var;
    logic                last_in;

    modport source (output valid, jacobian, state_var, act_mean, act_var,
                    observation, noise_var, last_in, input ready);
    modport sink   (input valid, jacobian, state_var, act_mean, act_var,
                    observation, noise_var, last_in, output ready);
endinterface

interface gou_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  mean_delta;
    logic signed [31:0]  var_delta;
    logic                zeroed;
    logic                last_out;

    modport source (output valid, mean_delta, var_delta, zeroed, last_out,
                    input ready);
    modport sink   (input valid, mean_delta, var_delta, zeroed, last_out,
                    output ready);
endinterface

/* design/gou_div.sv */
// ----------------------------------------------------------------------------
// gou_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module gou_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  gou_pkg::t_div i_stage,
    output logic          o_valid,
    output gou_pkg::t_div o_stage
);
    import gou_pkg::*;

    t_div r_st  [QUO_W];
    logic r_vld [QUO_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(i_stage, QUO_W - 1);
            for (int k = 1; k < QUO_W; k++) begin
                r_st[k] <= div_step(r_st[k-1], QUO_W - 1 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < QUO_W; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_stage = r_st[QUO_W-1];

endmodule

/* design/gaussian_output_update.sv */
// ----------------------------------------------------------------------------
// gaussian_output_update
// Output-layer Gaussian update: gain, mean delta and variance delta per unit.
// ----------------------------------------------------------------------------
// Each beat passes stage 0, stage 1, the divider and post stages 1 and 2.
// Throughput is one beat per cycle; the 32-stage quotient pipeline sets depth.
// The whole pipeline advances together and halts while an output beat waits.
// Reset clears every valid bit; payload registers are not reset.
module gaussian_output_update (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gou_in_if.sink    i_in,
    gou_out_if.source o_out
);
    import gou_pkg::*;

    // The pipeline moves when the output register is empty or being drained.
    logic w_en;
    assign w_en     = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // Stage 0: operand conditioning. Magnitude and sign of the Jacobian,
    // the exact denominator and the exact innovation y - ma.
    logic              r_s0_vld;
    logic              r_s0_jneg;
    logic [DATA_W-1:0] r_s0_jmag;
    logic [VAR_W-1:0]  r_s0_sz;
    logic [QUO_W-1:0]  r_s0_den;
    logic              r_s0_dneg;
    logic [DIFF_W-1:0] r_s0_dmag;
    logic              r_s0_last;

    logic [DIFF_W-1:0] w_diff;
    assign w_diff = {i_in.observation[DATA_W-1], i_in.observation}
                  - {i_in.act_mean[DATA_W-1], i_in.act_mean};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_jneg <= i_in.jacobian[DATA_W-1];
            r_s0_jmag <= i_in.jacobian[DATA_W-1] ? (DATA_W'(0) - i_in.jacobian)
                                                 : i_in.jacobian;
            r_s0_sz   <= i_in.state_var;
            r_s0_den  <= {1'b0, i_in.act_var} + {1'b0, i_in.noise_var};
            r_s0_dneg <= w_diff[DIFF_W-1];
            r_s0_dmag <= w_diff[DIFF_W-1] ? (DIFF_W'(0) - w_diff) : w_diff;
            r_s0_last <= i_in.last_in;
        end
    end

    // Stage 1: numerator |J| * Sz, exact, with twice the fraction bits.
    logic              r_s1_vld;
    logic [NUM_W-1:0]  r_s1_num;
    logic [QUO_W-1:0]  r_s1_den;
    logic              r_s1_jneg;
    logic              r_s1_dneg;
    logic [DIFF_W-1:0] r_s1_dmag;
    logic              r_s1_last;

    logic [DATA_W+VAR_W-1:0] w_num;
    assign w_num = r_s0_jmag * r_s0_sz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_num  <= w_num[NUM_W-1:0];
            r_s1_den  <= r_s0_den;
            r_s1_jneg <= r_s0_jneg;
            r_s1_dneg <= r_s0_dneg;
            r_s1_dmag <= r_s0_dmag;
            r_s1_last <= r_s0_last;
        end
    end

    // Divider entry. A quotient that needs more than 32 bits is flagged up
    // front; a zero denominator lands in the same flag, since any upper
    // numerator part is at least zero.
    t_div w_div_in;
    t_div w_div_out;
    logic w_div_vld;

    always_comb begin
        w_div_in      = '0;
        w_div_in.rem  = QUO_W'(r_s1_num[NUM_W-1:QUO_W]);
        w_div_in.num  = r_s1_num;
        w_div_in.den  = r_s1_den;
        w_div_in.ovf  = QUO_W'(r_s1_num[NUM_W-1:QUO_W]) >= r_s1_den;
        w_div_in.jneg = r_s1_jneg;
        w_div_in.dneg = r_s1_dneg;
        w_div_in.dmag = r_s1_dmag;
        w_div_in.last = r_s1_last;
    end

    gou_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s1_vld),
        .i_stage (w_div_in),
        .o_valid (w_div_vld),
        .o_stage (w_div_out)
    );

    // Post stage 1: range check of the gain and the products. The variance
    // product is split into two 32 x 31 partial products on the numerator.
    logic                r_p1_vld;
    logic                r_p1_zero;
    logic                r_p1_mneg;
    logic                r_p1_vneg;
    logic [MPROD_W-1:0]  r_p1_mprod;
    logic [PPROD_W-1:0]  r_p1_vlo;
    logic [PPROD_W-1:0]  r_p1_vhi;
    logic                r_p1_last;

    logic w_gneg;
    assign w_gneg = w_div_out.jneg && (w_div_out.quo != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_zero  <= w_div_out.ovf
                       || (w_div_out.quo > (w_gneg ? NEG_CAP : POS_CAP));
            r_p1_mneg  <= w_gneg ^ w_div_out.dneg;
            r_p1_vneg  <= (w_gneg == w_div_out.jneg);
            r_p1_mprod <= w_div_out.quo * w_div_out.dmag;
            r_p1_vlo   <= w_div_out.quo * w_div_out.num[VAR_W-1:0];
            r_p1_vhi   <= w_div_out.quo * w_div_out.num[NUM_W-1:VAR_W];
            r_p1_last  <= w_div_out.last;
        end
    end

    // Post stage 2: recombine, rescale and saturate into the output register.
    logic [VPROD_W-1:0] w_vsum;
    logic [VPROD_W-1:0] w_mmag;
    logic [VPROD_W-1:0] w_vmag;

    assign w_vsum = {r_p1_vhi, {VAR_W{1'b0}}} + VPROD_W'(r_p1_vlo);
    assign w_mmag = VPROD_W'(r_p1_mprod >> FRAC_BITS);
    assign w_vmag = w_vsum >> (2 * FRAC_BITS);

    logic              r_o_vld;
    logic [DATA_W-1:0] r_o_mean;
    logic [DATA_W-1:0] r_o_var;
    logic              r_o_zero;
    logic              r_o_last;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_mean <= r_p1_zero ? '0 : sat_mag(r_p1_mneg, w_mmag);
            r_o_var  <= r_p1_zero ? '0 : sat_mag(r_p1_vneg, w_vmag);
            r_o_zero <= r_p1_zero;
            r_o_last <= r_p1_last;
        end
    end

    // Valid bits of the stages outside the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_in.valid;
            r_s1_vld <= r_s0_vld;
            r_p1_vld <= w_div_vld;
            r_o_vld  <= r_p1_vld;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.mean_delta = r_o_mean;
    assign o_out.var_delta  = r_o_var;
    assign o_out.zeroed     = r_o_zero;
    assign o_out.last_out   = r_o_last;

    // A forced result carries two zero deltas.
`include "gaussian_output_update_assert.svh"
    `GOU_ASSERT_IMPLY(a_zeroed_clears, r_o_vld && r_o_zero,
                      (r_o_mean == '0) && (r_o_var == '0))
    // The variance update never increases the variance.
    `GOU_ASSERT_IMPLY(a_var_nonpos, r_o_vld, r_o_var[DATA_W-1] || (r_o_var == '0))
    // Coming out of reset the output register and post stage 1 are empty.
    `GOU_ASSERT_NEXT(a_reset_empty, !i_rst_n, !r_o_vld && !r_p1_vld)

endmodule
